// File: hw/rtl/pgm_stream_decoder_macros.svh
// assertion macros shared by the grey-map stream decoder modules
`ifndef PGM_STREAM_DECODER_MACROS_SVH
`define PGM_STREAM_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PGM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pgm decoder check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PGM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pgm decoder check failed");

`endif

// File: hw/rtl/pgm_pkg.sv
// shared types, codes and result builders for the grey-map stream decoder
package pgm_pkg;

	// input item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	// result kinds
	localparam logic [1:0] RK_HEADER = 2'd0;
	localparam logic [1:0] RK_PIXEL  = 2'd1;
	localparam logic [1:0] RK_ERROR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_BAD_MAGIC   = 3'd0;
	localparam logic [2:0] ERR_BAD_HEADER  = 3'd1;
	localparam logic [2:0] ERR_BAD_NUMBER  = 3'd2;
	localparam logic [2:0] ERR_TRUNC_ASCII = 3'd3;
	localparam logic [2:0] ERR_TRUNC_BIN   = 3'd4;

	// one input item
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} byte_t;

	// one result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] max_value;
		logic        is_binary;
		logic [15:0] pixel_value;
		logic [31:0] pixel_index;
		logic        last_pixel;
		logic [2:0]  error_code;
		logic        run_last;
	} result_t;

	// queue entry: first result, plus an optional trailing error
	typedef struct packed {
		result_t    first;
		logic       two;
		logic [2:0] second_err;
	} qent_t;

	function automatic result_t mk_error(input logic [2:0] code);
		result_t r;
		r = '0;
		r.result_kind = RK_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t mk_header(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] m, input logic bin);
		result_t r;
		r = '0;
		r.result_kind = RK_HEADER;
		r.image_width = w;
		r.image_height = h;
		r.max_value = m;
		r.is_binary = bin;
		return r;
	endfunction

	function automatic result_t mk_pixel(input logic bin, input logic [15:0] v,
			input logic [31:0] idx, input logic last);
		result_t r;
		r = '0;
		r.result_kind = RK_PIXEL;
		r.is_binary = bin;
		r.pixel_value = v;
		r.pixel_index = idx;
		r.last_pixel = last;
		return r;
	endfunction

endpackage

// File: hw/rtl/pgm_stream_decoder.sv
// grey-map (P2/P5) byte stream decoder, top level
// Each result passes through the queue and then the output register before it is presented.
// Throughput: one byte per cycle while the queue is not full; an end-of-stream item
// with two results shows them one after the other; the four-entry queue absorbs the burst.
// The pixel total comes from a 16x16 multiplier registered once the height is known.
// Reset: arst_n asynchronously clears parser, queue and output control state; ready at once.
module pgm_stream_decoder import pgm_pkg::*; #(
	parameter int DIM_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    byte_valid,
	output logic    byte_stall,
	input  byte_t   byte_data,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	logic  push, pop, full, empty;
	qent_t push_data, pop_data;

	// byte parser
	pgm_front #(
		.DIM_BITS(DIM_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.queue_full(full),
		.push(push),
		.push_data(push_data)
	);

	// decoupling queue
	pgm_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	// result output
	pgm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop_data(pop_data),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

endmodule

// File: hw/rtl/pgm_fifo.sv
// small flop-based queue between the parser front and the output back
`include "pgm_stream_decoder_macros.svh"

module pgm_fifo import pgm_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output qent_t pop_data,
	output logic  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	qent_t               mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PGM_ASSERT_NOW(a_no_overflow, full, !push)
	`PGM_ASSERT_NOW(a_no_underflow, empty, !pop)
	`PGM_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1))

endmodule

// File: hw/rtl/pgm_front.sv
// parser front: accepts file bytes, tracks the header and raster, emits result entries
module pgm_front import pgm_pkg::*; #(
	parameter int DIM_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  byte_valid,
	output logic  byte_stall,
	input  byte_t byte_data,
	input  logic  queue_full,
	output logic  push,
	output qent_t push_data
);

	localparam int CNT_BITS = 2 * DIM_BITS;
	localparam logic [16:0] DIM_MAX = 17'((1 << DIM_BITS) - 1);

	// characters of interest
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_5    = 8'h35;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_SP   = 8'h20;

	// magic token progress codes
	localparam logic [2:0] MAG_EMPTY = 3'd0;
	localparam logic [2:0] MAG_P     = 3'd1;
	localparam logic [2:0] MAG_P2    = 3'd2;
	localparam logic [2:0] MAG_P5    = 3'd3;
	localparam logic [2:0] MAG_BAD   = 3'd4;

	localparam logic [16:0] ACC_SAT = 17'd65536;

	typedef enum logic [2:0] {
		PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII, PH_BIN, PH_STOP
	} phase_t;

	phase_t              phase_q, nx_phase;
	logic [2:0]          magic_q, nx_magic;
	logic [16:0]         accum_q, nx_accum;
	logic                active_q, nx_active;
	logic                junk_q, nx_junk;
	logic                nodig_q, nx_nodig;
	logic                comment_q, nx_comment;
	logic [15:0]         width_q, nx_width;
	logic [15:0]         height_q, nx_height;
	logic [15:0]         maxval_q, nx_maxval;
	logic [CNT_BITS-1:0] count_q, nx_count;
	logic [8:0]          held_q, nx_held;
	logic [CNT_BITS-1:0] total_q;

	logic          accept, is_eos, b_digit, b_space, tok_ok, bin_mode;
	logic          do_fin, do_pix, pix_last, has0, two;
	logic [7:0]    b;
	logic [3:0]    dval;
	logic [19:0]   acc_next;
	logic [15:0]   pix_val;
	logic [CNT_BITS:0] cnt_inc;
	logic [2:0]    sec_err;
	logic          sec_has;
	result_t       res0;

	assign byte_stall = queue_full;
	assign accept = byte_valid && !byte_stall;
	assign is_eos = (byte_data.kind == KIND_EOS);
	assign b = byte_data.data_byte;
	assign dval = 4'(b - CH_0);
	assign b_digit = (b >= CH_0) && (b <= CH_9);
	assign b_space = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
	assign tok_ok = active_q && !nodig_q && !accum_q[16];
	assign bin_mode = (magic_q == MAG_P5);
	assign acc_next = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0} + {16'd0, dval};
	assign cnt_inc = {1'b0, count_q} + 1'b1;
	assign pix_last = (cnt_inc >= {1'b0, total_q});

	// a token is finished by white space, or by end of stream in the header or a raster token
	always_comb begin
		do_fin = 1'b0;
		if (accept) begin
			if (is_eos) begin
				do_fin = (phase_q <= PH_MAXVAL) || ((phase_q == PH_ASCII) && active_q);
			end else if ((phase_q != PH_BIN) && (phase_q != PH_STOP)) begin
				do_fin = !comment_q && (b != CH_HASH) && b_space && active_q;
			end
		end
	end

	// next state and result entry
	always_comb begin
		nx_phase = phase_q;
		nx_magic = magic_q;
		nx_accum = accum_q;
		nx_active = active_q;
		nx_junk = junk_q;
		nx_nodig = nodig_q;
		nx_comment = comment_q;
		nx_width = width_q;
		nx_height = height_q;
		nx_maxval = maxval_q;
		nx_count = count_q;
		nx_held = held_q;
		res0 = '0;
		has0 = 1'b0;
		two = 1'b0;
		do_pix = 1'b0;
		pix_val = accum_q[15:0];
		sec_err = ERR_BAD_NUMBER;
		sec_has = 1'b0;

		// finish the pending token
		if (do_fin) begin
			nx_accum = '0;
			nx_active = 1'b0;
			nx_junk = 1'b0;
			nx_nodig = 1'b0;
			if (phase_q == PH_MAGIC) begin
				if ((magic_q == MAG_P2) || (magic_q == MAG_P5)) begin
					nx_phase = PH_WIDTH;
				end else begin
					res0 = mk_error(ERR_BAD_MAGIC);
					has0 = 1'b1;
					nx_phase = PH_STOP;
				end
			end else if (!tok_ok) begin
				res0 = mk_error(ERR_BAD_NUMBER);
				has0 = 1'b1;
				nx_phase = PH_STOP;
			end else begin
				case (phase_q)
					PH_WIDTH: begin
						nx_width = accum_q[15:0];
						nx_phase = PH_HEIGHT;
					end
					PH_HEIGHT: begin
						nx_height = accum_q[15:0];
						nx_phase = PH_MAXVAL;
					end
					PH_MAXVAL: begin
						nx_maxval = accum_q[15:0];
						if ((width_q == '0) || (height_q == '0) || (accum_q[15:0] == '0) ||
								({1'b0, width_q} > DIM_MAX) || ({1'b0, height_q} > DIM_MAX)) begin
							res0 = mk_error(ERR_BAD_HEADER);
							has0 = 1'b1;
							nx_phase = PH_STOP;
						end else begin
							nx_count = '0;
							nx_held = '0;
							nx_phase = bin_mode ? PH_BIN : PH_ASCII;
							res0 = mk_header(width_q, height_q, accum_q[15:0], bin_mode);
							has0 = 1'b1;
						end
					end
					PH_ASCII: begin
						do_pix = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end

		// data bytes outside a token finish
		if (accept && !is_eos) begin
			if (phase_q == PH_BIN) begin
				if (maxval_q[15:8] == '0) begin
					do_pix = 1'b1;
					pix_val = {8'd0, b};
				end else if (held_q[8]) begin
					do_pix = 1'b1;
					pix_val = {held_q[7:0], b};
					nx_held = '0;
				end else begin
					nx_held = {1'b1, b};
				end
			end else if (phase_q != PH_STOP) begin
				if (comment_q) begin
					if (b == CH_LF) begin
						nx_comment = 1'b0;
					end
				end else if (b == CH_HASH) begin
					nx_comment = 1'b1;
				end else if (!b_space) begin
					// add one character to the token
					if (phase_q == PH_MAGIC) begin
						if (!active_q) begin
							nx_magic = (b == CH_P) ? MAG_P : MAG_BAD;
						end else if (magic_q == MAG_P) begin
							nx_magic = (b == CH_2) ? MAG_P2 : ((b == CH_5) ? MAG_P5 : MAG_BAD);
						end else begin
							nx_magic = MAG_BAD;
						end
					end else if (!active_q) begin
						if (b_digit) begin
							nx_accum = {13'd0, dval};
						end else begin
							nx_nodig = 1'b1;
						end
					end else if (!nodig_q && !junk_q) begin
						if (b_digit) begin
							nx_accum = (acc_next > {3'd0, ACC_SAT}) ? ACC_SAT : acc_next[16:0];
						end else begin
							nx_junk = 1'b1;
						end
					end
					nx_active = 1'b1;
				end
			end
		end

		// pixel result
		if (do_pix) begin
			res0 = mk_pixel(bin_mode, pix_val, 32'(count_q), pix_last);
			has0 = 1'b1;
			nx_count = cnt_inc[CNT_BITS-1:0];
			if (pix_last) begin
				nx_phase = PH_STOP;
			end
		end

		// end of stream: trailing error, then rearm
		if (accept && is_eos) begin
			case (nx_phase)
				PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
					sec_has = 1'b1;
					sec_err = ERR_BAD_NUMBER;
				end
				PH_ASCII: begin
					sec_has = 1'b1;
					sec_err = ERR_TRUNC_ASCII;
				end
				PH_BIN: begin
					sec_has = 1'b1;
					sec_err = ERR_TRUNC_BIN;
				end
				default: begin
				end
			endcase
			if (sec_has) begin
				if (has0) begin
					two = 1'b1;
				end else begin
					res0 = mk_error(sec_err);
					has0 = 1'b1;
				end
			end
			nx_phase = PH_MAGIC;
			nx_magic = MAG_EMPTY;
			nx_accum = '0;
			nx_active = 1'b0;
			nx_junk = 1'b0;
			nx_nodig = 1'b0;
			nx_comment = 1'b0;
			nx_width = '0;
			nx_height = '0;
			nx_maxval = '0;
			nx_count = '0;
			nx_held = '0;
		end
	end

	assign push = accept && has0;
	assign push_data = '{first: res0, two: two, second_err: sec_err};

	// parser state, plus the pixel total from the stored dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			magic_q <= MAG_EMPTY;
			accum_q <= '0;
			active_q <= 1'b0;
			junk_q <= 1'b0;
			nodig_q <= 1'b0;
			comment_q <= 1'b0;
			width_q <= '0;
			height_q <= '0;
			maxval_q <= '0;
			count_q <= '0;
			held_q <= '0;
			total_q <= '0;
		end else begin
			phase_q <= nx_phase;
			magic_q <= nx_magic;
			accum_q <= nx_accum;
			active_q <= nx_active;
			junk_q <= nx_junk;
			nodig_q <= nx_nodig;
			comment_q <= nx_comment;
			width_q <= nx_width;
			height_q <= nx_height;
			maxval_q <= nx_maxval;
			count_q <= nx_count;
			held_q <= nx_held;
			total_q <= CNT_BITS'(width_q[DIM_BITS-1:0]) * CNT_BITS'(height_q[DIM_BITS-1:0]);
		end
	end

endmodule

// File: hw/rtl/pgm_back.sv
// output back: takes queue entries and drives results out through a register
`include "pgm_stream_decoder_macros.svh"

module pgm_back import pgm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  qent_t   pop_data,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	logic       out_valid_q;
	result_t    out_q;
	logic       pend_q;
	logic [2:0] pend_err_q;
	logic       load;
	result_t    first_r;
	result_t    second_r;

	assign load = !out_valid_q || !result_stall;
	assign pop = load && !pend_q && !empty;
	assign result_valid = out_valid_q;
	assign result_data = out_q;

	// tag run_last on each result of an item
	always_comb begin
		first_r = pop_data.first;
		first_r.run_last = !pop_data.two;
		second_r = mk_error(pend_err_q);
		second_r.run_last = 1'b1;
	end

	// output register and the held trailing error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
			pend_err_q <= ERR_BAD_MAGIC;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (!empty) begin
				out_valid_q <= 1'b1;
				pend_q <= pop_data.two;
				pend_err_q <= pop_data.second_err;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= second_r;
			end else if (!empty) begin
				out_q <= first_r;
			end
		end
	end

	`PGM_ASSERT_NOW(a_pend_shows_first, pend_q, out_valid_q && !out_q.run_last)
	`PGM_ASSERT_NEXT(a_second_is_error, pend_q && !result_stall,
		out_valid_q && (out_q.result_kind == RK_ERROR) && out_q.run_last)
	`PGM_ASSERT_NEXT(a_drain_idle, out_valid_q && !result_stall && !pend_q && empty,
		!out_valid_q)

endmodule

// File: tb/pgm_stream_decoder_tb.sv
// testbench for the grey-map stream decoder: random P2/P5 byte streams checked against a predictor
`timescale 1ns / 1ps

module pgm_stream_decoder_tb;
	import pgm_pkg::*;

	localparam int DIM_BITS = 16;
	localparam logic [31:0] DIM_MAX = (32'd1 << DIM_BITS) - 32'd1;
	localparam int LONG_HOLD = 300;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	// kinds of damage a generated image file can carry
	localparam int FL_CUT_LO   = 16;
	localparam int FL_CUT_HI   = 18;
	localparam int FL_MAGIC    = 19;
	localparam int FL_SIGN     = 20;
	localparam int FL_OVER     = 21;
	localparam int FL_ZERO     = 22;
	localparam int FL_PIXSIGN  = 23;

	typedef enum logic [2:0] {
		S_MAGIC, S_WIDTH, S_HEIGHT, S_MAXVAL, S_ASCII, S_BINARY, S_DONE
	} stage_t;

	typedef enum logic [2:0] {
		MG_NONE, MG_P, MG_P2, MG_P5, MG_BAD
	} magic_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	byte_t   byte_data = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	pgm_stream_decoder #(
		.DIM_BITS(DIM_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus store and flags shared with the driver and receiver
	byte_t      byte_backlog[$];
	logic [7:0] file_bytes[$];
	int         items_queued = 0;
	bit         calm_tail = 1'b0;
	bit         hold_request = 1'b0;

	// predicted results and check bookkeeping
	result_t want_results[$];
	result_t step_results[$];
	int      mismatches = 0;
	int      results_seen = 0;

	// decoder shadow state
	stage_t      p_stage;
	magic_t      p_magic;
	logic [16:0] p_acc;
	logic        p_tok;
	logic        p_junk;
	logic        p_nodig;
	logic        p_cmt;
	logic [15:0] p_w;
	logic [15:0] p_h;
	logic [15:0] p_max;
	logic [31:0] p_cnt;
	logic [8:0]  p_hi;

	// ---------------------------------------------------------------- predictor

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || b == "\t" || b == "\n" || b == CH_VT || b == CH_FF || b == "\r";
	endfunction

	task automatic clear_token();
		p_acc = '0;
		p_tok = 1'b0;
		p_junk = 1'b0;
		p_nodig = 1'b0;
	endtask

	task automatic reset_decoder();
		p_stage = S_MAGIC;
		p_magic = MG_NONE;
		clear_token();
		p_cmt = 1'b0;
		p_w = '0;
		p_h = '0;
		p_max = '0;
		p_cnt = '0;
		p_hi = '0;
	endtask

	task automatic emit_error(input logic [2:0] code);
		result_t r;
		r = '0;
		r.result_kind = RK_ERROR;
		r.error_code = code;
		p_stage = S_DONE;
		step_results.push_back(r);
	endtask

	task automatic emit_pixel(input logic [15:0] v);
		result_t r;
		logic [63:0] total;
		logic last;
		total = {48'd0, p_w} * {48'd0, p_h};
		last = ({32'd0, p_cnt} + 64'd1) >= total;
		r = '0;
		r.result_kind = RK_PIXEL;
		r.is_binary = (p_magic == MG_P5);
		r.pixel_value = v;
		r.pixel_index = p_cnt;
		r.last_pixel = last;
		p_cnt = p_cnt + 32'd1;
		if (last)
			p_stage = S_DONE;
		step_results.push_back(r);
	endtask

	// one non-space, non-comment character joins the current token
	task automatic take_char(input logic [7:0] b);
		logic digit;
		logic [31:0] v;
		digit = (b >= "0" && b <= "9");
		if (p_stage == S_MAGIC) begin
			if (!p_tok)
				p_magic = (b == "P") ? MG_P : MG_BAD;
			else if (p_magic == MG_P)
				p_magic = (b == "2") ? MG_P2 : ((b == "5") ? MG_P5 : MG_BAD);
			else
				p_magic = MG_BAD;
		end else if (!p_tok) begin
			if (digit)
				p_acc = {9'd0, b - "0"};
			else
				p_nodig = 1'b1;
		end else if (!p_nodig && !p_junk) begin
			if (digit) begin
				v = {15'd0, p_acc} * 32'd10 + {24'd0, b} - {24'd0, "0"};
				p_acc = (v > 32'd65536) ? 17'd65536 : v[16:0];
			end else begin
				p_junk = 1'b1;
			end
		end
		p_tok = 1'b1;
	endtask

	task automatic end_token();
		logic ok;
		logic [16:0] v;
		stage_t st;
		result_t r;
		ok = p_tok && !p_nodig && (p_acc <= 17'd65535);
		v = p_acc;
		st = p_stage;
		clear_token();
		if (st == S_MAGIC) begin
			if (p_magic == MG_P2 || p_magic == MG_P5)
				p_stage = S_WIDTH;
			else
				emit_error(ERR_BAD_MAGIC);
		end else if (!ok) begin
			emit_error(ERR_BAD_NUMBER);
		end else begin
			case (st)
				S_WIDTH: begin
					p_w = v[15:0];
					p_stage = S_HEIGHT;
				end
				S_HEIGHT: begin
					p_h = v[15:0];
					p_stage = S_MAXVAL;
				end
				S_MAXVAL: begin
					p_max = v[15:0];
					if (p_w == 0 || p_h == 0 || p_max == 0 || p_w > DIM_MAX || p_h > DIM_MAX) begin
						emit_error(ERR_BAD_HEADER);
					end else begin
						p_cnt = '0;
						p_hi = '0;
						p_stage = (p_magic == MG_P5) ? S_BINARY : S_ASCII;
						r = '0;
						r.result_kind = RK_HEADER;
						r.image_width = p_w;
						r.image_height = p_h;
						r.max_value = p_max;
						r.is_binary = (p_magic == MG_P5);
						step_results.push_back(r);
					end
				end
				S_ASCII: emit_pixel(v[15:0]);
				default: ;
			endcase
		end
	endtask

	// work out the results of one accepted item and queue them
	task automatic decode_byte(input byte_t it);
		logic [7:0] b;
		logic [15:0] pv;
		result_t r;
		b = it.data_byte;
		step_results.delete();
		if (it.kind == KIND_EOS) begin
			if (p_stage <= S_MAXVAL || (p_stage == S_ASCII && p_tok))
				end_token();
			if (p_stage >= S_WIDTH && p_stage <= S_MAXVAL)
				emit_error(ERR_BAD_NUMBER);
			else if (p_stage == S_ASCII)
				emit_error(ERR_TRUNC_ASCII);
			else if (p_stage == S_BINARY)
				emit_error(ERR_TRUNC_BIN);
			reset_decoder();
		end else if (p_stage == S_BINARY) begin
			if (p_max < 16'd256) begin
				emit_pixel({8'd0, b});
			end else if (p_hi[8]) begin
				pv = {p_hi[7:0], b};
				p_hi = '0;
				emit_pixel(pv);
			end else begin
				p_hi = {1'b1, b};
			end
		end else if (p_stage != S_DONE) begin
			if (p_cmt) begin
				if (b == "\n")
					p_cmt = 1'b0;
			end else if (b == "#") begin
				p_cmt = 1'b1;
			end else if (is_space(b)) begin
				if (p_tok)
					end_token();
			end else begin
				take_char(b);
			end
		end
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.run_last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i])
			want_results.push_back(step_results[i]);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	task automatic check_result(input result_t got);
		result_t w;
		if (want_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
		end else begin
			w = want_results.pop_front();
			cmp_field("result_kind", 32'(got.result_kind), 32'(w.result_kind));
			cmp_field("image_width", 32'(got.image_width), 32'(w.image_width));
			cmp_field("image_height", 32'(got.image_height), 32'(w.image_height));
			cmp_field("max_value", 32'(got.max_value), 32'(w.max_value));
			cmp_field("is_binary", 32'(got.is_binary), 32'(w.is_binary));
			cmp_field("pixel_value", 32'(got.pixel_value), 32'(w.pixel_value));
			cmp_field("pixel_index", got.pixel_index, w.pixel_index);
			cmp_field("last_pixel", 32'(got.last_pixel), 32'(w.last_pixel));
			cmp_field("error_code", 32'(got.error_code), 32'(w.error_code));
			cmp_field("run_last", 32'(got.run_last), 32'(w.run_last));
		end
		results_seen++;
	endtask

	// ---------------------------------------------------------------- driver and receiver

	function automatic int pick_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4;
			2: return 10;
			default: return 30;
		endcase
	endfunction

	int tx_gap;
	int tx_odds;
	int rx_hold;
	int rx_odds;
	bit held_long;

	// byte driver: predicts each accepted item, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
			tx_gap <= 0;
			tx_odds <= 4;
			reset_decoder();
		end else begin
			if (byte_valid && !byte_stall)
				decode_byte(byte_data);
			if ($urandom_range(0, 127) == 0)
				tx_odds <= pick_odds();
			if (!byte_valid || !byte_stall) begin
				if (tx_gap > 0) begin
					byte_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (!calm_tail && tx_odds > 0 && $urandom_range(1, tx_odds) == 1) begin
					byte_valid <= 1'b0;
					tx_gap <= $urandom_range(0, 12);
				end else if (byte_backlog.size() > 0) begin
					byte_valid <= 1'b1;
					byte_data <= byte_backlog.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: checks each accepted result, stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_hold <= 0;
			rx_odds <= 4;
			held_long <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result_data);
			if ($urandom_range(0, 127) == 0)
				rx_odds <= pick_odds();
			if (hold_request && !held_long) begin
				held_long <= 1'b1;
				rx_hold <= LONG_HOLD;
				result_stall <= 1'b1;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				result_stall <= 1'b1;
			end else if (!calm_tail && rx_odds > 0 && $urandom_range(1, rx_odds) == 1) begin
				rx_hold <= $urandom_range(0, 12);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- stream builders

	task automatic push_item(input logic k, input logic [7:0] b);
		byte_t it;
		it.kind = k;
		it.data_byte = b;
		byte_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		file_bytes.push_back(b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 9))
			0: return "\t";
			1: return "\n";
			2: return CH_VT;
			3: return CH_FF;
			4: return "\r";
			default: return " ";
		endcase
	endfunction

	task automatic put_comment();
		logic [7:0] c;
		put_byte("#");
		repeat ($urandom_range(0, 6)) begin
			c = 8'($urandom_range(0, 255));
			put_byte((c == "\n") ? " " : c);
		end
		put_byte("\n");
	endtask

	task automatic put_gap();
		put_byte(pick_space());
		if ($urandom_range(0, 5) == 0) begin
			put_comment();
			if ($urandom_range(0, 1) == 0)
				put_byte(pick_space());
		end
		if ($urandom_range(0, 3) == 0)
			put_byte(pick_space());
	endtask

	task automatic put_noise(input int n);
		repeat (n)
			put_byte(8'($urandom_range(0, 255)));
	endtask

	// decimal token, sometimes zero padded, split by a comment or with a junk tail
	task automatic put_number(input int v, input bit junk);
		string s;
		int k;
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0)
			s = {"0", s};
		if (s.len() > 1 && $urandom_range(0, 9) == 0) begin
			k = $urandom_range(1, s.len() - 1);
			put_text(s.substr(0, k - 1));
			put_comment();
			put_text(s.substr(k, s.len() - 1));
		end else begin
			put_text(s);
		end
		if (junk)
			put_byte(8'($urandom_range("a", "z")));
	endtask

	task automatic put_bad_magic();
		case ($urandom_range(0, 5))
			0: put_text("P3");
			1: put_text("p2");
			2: put_text("P");
			3: put_text("P25");
			4: put_text("5P");
			default: put_text("X7");
		endcase
	endtask

	// hand the built file to the driver, optionally cut short, closed by end of stream
	task automatic send_file(input bit cut);
		int keep;
		if (cut && file_bytes.size() > 0) begin
			keep = $urandom_range(0, file_bytes.size() - 1);
			while (file_bytes.size() > keep)
				file_bytes.delete(file_bytes.size() - 1);
		end
		foreach (file_bytes[i])
			push_item(KIND_DATA, file_bytes[i]);
		push_item(KIND_EOS, 8'($urandom_range(0, 255)));
		file_bytes.delete();
	endtask

	task automatic build_image();
		int w, h, mv, v, flaw, fk, npix, nbytes;
		int hv[3];
		bit bin;
		bin = 1'($urandom_range(0, 1));
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
		h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
		case ($urandom_range(0, 5))
			0: mv = 1;
			1: mv = 255;
			2: mv = 256;
			3: mv = 65535;
			4: mv = $urandom_range(2, 254);
			default: mv = $urandom_range(257, 65534);
		endcase
		flaw = $urandom_range(0, 23);
		fk = $urandom_range(0, 2);
		hv[0] = w;
		hv[1] = h;
		hv[2] = mv;

		// magic token
		if ($urandom_range(0, 3) == 0)
			put_gap();
		if (flaw == FL_MAGIC) begin
			put_bad_magic();
		end else if ($urandom_range(0, 7) == 0) begin
			put_byte("P");
			put_comment();
			put_byte(bin ? "5" : "2");
		end else begin
			put_text(bin ? "P5" : "P2");
		end
		put_gap();

		// width, height, maxval
		for (int k = 0; k < 3; k++) begin
			if (flaw == FL_ZERO && k == fk)
				put_number(0, 1'b0);
			else if (flaw == FL_OVER && k == fk)
				put_number($urandom_range(65536, 99999), 1'b0);
			else if (flaw == FL_SIGN && k == fk) begin
				put_byte($urandom_range(0, 1) ? "+" : "-");
				put_number(hv[k], 1'b0);
			end else
				put_number(hv[k], $urandom_range(0, 11) == 0);
			if (k < 2 || !bin)
				put_gap();
			else begin
				// binary raster starts right after one white-space byte
				if ($urandom_range(0, 5) == 0)
					put_comment();
				put_byte(pick_space());
			end
		end

		if (flaw >= FL_MAGIC && flaw <= FL_ZERO) begin
			if ($urandom_range(0, 2) == 0)
				put_noise($urandom_range(1, 3));
			send_file(1'b0);
		end else begin
			// raster
			npix = w * h;
			if (!bin) begin
				for (int i = 0; i < npix; i++) begin
					v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 69999) :
						$urandom_range(0, mv);
					if (flaw == FL_PIXSIGN && i == npix / 2)
						put_byte("-");
					put_number(v, $urandom_range(0, 14) == 0);
					if (i < npix - 1 || $urandom_range(0, 1) == 0)
						put_gap();
				end
			end else begin
				nbytes = (mv < 256) ? npix : 2 * npix;
				put_noise(nbytes);
			end
			if ($urandom_range(0, 3) == 0)
				put_noise($urandom_range(1, 4));
			send_file(flaw >= FL_CUT_LO && flaw <= FL_CUT_HI);
		end
	endtask

	task automatic random_file();
		case ($urandom_range(0, 9))
			0: begin
				put_noise($urandom_range(1, 12));
				send_file(1'b0);
			end
			1: begin
				put_text($urandom_range(0, 1) ? "P5" : "P2");
				put_gap();
				put_noise($urandom_range(1, 10));
				send_file(1'b0);
			end
			default: build_image();
		endcase
	endtask

	task automatic wait_drained();
		while (byte_backlog.size() != 0 || byte_valid || want_results.size() != 0)
			@(negedge clk);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		#90 arst_n = 1'b1;
		@(negedge clk);

		// empty stream
		send_file(1'b0);
		// widest header, largest maxval, half a byte pair held at end of stream
		put_text("P5 65535 1 65535\n");
		put_byte(8'hAB);
		send_file(1'b0);
		// pixel above maxval, last token finished by end of stream
		put_text("P2 1 1 1 7");
		send_file(1'b0);
		wait_drained();

		// long receiver hold while a big binary raster keeps coming
		put_text("P5 20 20 255\n");
		put_noise(400);
		hold_request = 1'b1;
		send_file(1'b0);
		wait_drained();

		while (items_queued < 1450)
			random_file();
		while (byte_backlog.size() != 0)
			@(negedge clk);
		calm_tail = 1'b1;
		while (items_queued < 1650)
			random_file();
		wait_drained();
		repeat (20) @(negedge clk);

		if (want_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", want_results.size()));
		if (mismatches == 0)
			$display("pgm_stream_decoder_tb: done, clean");
		else
			$display("pgm_stream_decoder_tb: done, errors");
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("pgm_stream_decoder_tb: done, errors");
		$finish;
	end

endmodule
